// ===== hw/rtl/time_slice_task_scheduler_core_assert.svh =====
// Assertion macros for the time-slice task scheduler
`ifndef TIME_SLICE_TASK_SCHEDULER_CORE_ASSERT_SVH
`define TIME_SLICE_TASK_SCHEDULER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define TSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define TSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");
`else
`define TSC_ASSERT_IMPL(lbl, ante, cons)
`define TSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/tsts_pkg.sv =====
// Shared types, constants and helper functions of the time-slice task scheduler
package tsts_pkg;

    localparam int TASK_SLOTS_DEF = 16;

    localparam int SLOT_IDX_W = 4;
    localparam int COUNT_W    = 8;
    localparam int PRIO_W     = 8;
    localparam int LFSR_W     = 16;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int COUNT_SPAN = 5;

    localparam logic [LFSR_W-1:0]   LFSR_TAPS     = 16'hB400;
    localparam logic [LFSR_W-1:0]   SEED_RESET    = 16'd44257;
    localparam logic                POLICY_RESET  = 1'b0;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET  = 5'd2;
    localparam logic [PRIO_W-1:0]   PRIO_LO_RESET = 8'd1;
    localparam logic [PRIO_W-1:0]   PRIO_HI_RESET = 8'd10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLICY  = 3'd0,
        REG_ACTIVE  = 3'd1,
        REG_PRIO_LO = 3'd2,
        REG_PRIO_HI = 3'd3,
        REG_SEED    = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_LOAD_RD,
        ST_LOAD_CAP,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FILL_DRAW,
        ST_FILL_DIV,
        ST_FILL_WR,
        ST_DONE
    } state_t;

    // One slot of the task table
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PRIO_W-1:0]  prio;
    } slot_entry_t;

    // One Galois LFSR shift
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

    // Zero seed would lock the LFSR: load it as one
    function automatic logic [LFSR_W-1:0] seed_fix(input logic [LFSR_W-1:0] s);
        return (s == '0) ? LFSR_W'(1) : s;
    endfunction

    // Residue modulo five: 16 is 1 mod 5, so fold nibbles, then subtract
    function automatic logic [2:0] mod5(input logic [LFSR_W-1:0] v);
        logic [5:0] s;
        logic [4:0] t;
        s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
        t = 5'(s[5:4]) + 5'(s[3:0]);
        if (t >= 5'(3 * COUNT_SPAN))
        begin
            t = t - 5'(3 * COUNT_SPAN);
        end
        else if (t >= 5'(2 * COUNT_SPAN))
        begin
            t = t - 5'(2 * COUNT_SPAN);
        end
        else if (t >= 5'(COUNT_SPAN))
        begin
            t = t - 5'(COUNT_SPAN);
        end
        return t[2:0];
    endfunction

endpackage

// ===== hw/rtl/time_slice_task_scheduler_core.sv =====
// Time-slice task scheduler: slot table memory, pick/refill sequencer, output register
//
//  Channel | Direction | Handshake               | Beat contents
//  --------+-----------+-------------------------+---------------------------------------------
//  cfg     | in        | cfg_wr_en               | cfg_index, cfg_wr_data
//  in      | in        | in_valid / in_ready     | mode, slot_index, load_count, load_priority
//  out     | out       | out_valid / out_ready   | running_slot, switched, running_count, refilled
//
//  Load writes the slot, then reads back the running slot and captures it. A tick that keeps
//  the slot reads and counts it down; one that picks scans slots 1 to L - 1, L being the
//  clamped active slot count, with one table read per slot scanned. A refill draws and writes
//  each slot (two LFSR draws, 16-step remainder unit, one write) and then scans again.
//  Reset clears the table through per-slot valid bits, so no clearing pass is run.
//  A new beat is taken once the previous one is in the output register; a stalled
//  output only holds the sequencer at its last step.

`include "time_slice_task_scheduler_core_assert.svh"

module time_slice_task_scheduler_core #(
    parameter int TASK_SLOTS = tsts_pkg::TASK_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tsts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsts_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [tsts_pkg::SLOT_IDX_W-1:0]  slot_index,
    input  logic [tsts_pkg::COUNT_W-1:0]     load_count,
    input  logic [tsts_pkg::PRIO_W-1:0]      load_priority,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tsts_pkg::SLOT_IDX_W-1:0]  running_slot,
    output logic                             switched,
    output logic [tsts_pkg::COUNT_W-1:0]     running_count,
    output logic                             refilled
);
    import tsts_pkg::*;

    localparam int SLOT_W    = $clog2(TASK_SLOTS);
    localparam int LIM_W     = $clog2(TASK_SLOTS + 1);
    localparam int BIT_CNT_W = $clog2(LFSR_W);

    // Configuration registers
    logic                policy_reg;
    logic [ACTIVE_W-1:0] active_reg;
    logic [PRIO_W-1:0]   prio_lo_reg;
    logic [PRIO_W-1:0]   prio_hi_reg;

    // Sequencer state
    state_t              state_reg, state_next;
    logic [LFSR_W-1:0]   lfsr_reg, lfsr_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic [SLOT_W-1:0]   ptr_reg, ptr_next;
    logic [SLOT_W-1:0]   best_reg, best_next;
    logic [COUNT_W-1:0]  key_reg, key_next;
    logic [COUNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic                refill_done_reg, refill_done_next;
    logic                out_valid_reg, out_valid_next;

    // Captured input beat
    logic                mode_reg;
    logic [SLOT_IDX_W-1:0] idx_reg;
    logic [COUNT_W-1:0]  lcount_reg;
    logic [PRIO_W-1:0]   lprio_reg;

    // Refill datapath
    logic [COUNT_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [LFSR_W-1:0]   dvd_reg, dvd_next;
    logic [PRIO_W-1:0]   rem_reg, rem_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;

    // Result staging and output register
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                res_sw_reg, res_sw_next;
    logic [COUNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic                res_rf_reg, res_rf_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_sw_reg, out_sw_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic                out_rf_reg, out_rf_next;

    // Slot table memory
    slot_entry_t         mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] mem_valid_reg;
    slot_entry_t         rd_data_reg;
    logic                rd_valid_reg;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    slot_entry_t         mem_wdata;
    logic                mem_re;
    logic [SLOT_W-1:0]   mem_raddr;
    slot_entry_t         rd_entry;

    // Derived configuration
    logic [PRIO_W-1:0]   lo_eff;
    logic [PRIO_W-1:0]   hi_eff;
    logic [PRIO_W-1:0]   span;
    logic [LIM_W-1:0]    limit;
    logic                scan_last;
    logic                load_ok;

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign running_slot  = SLOT_IDX_W'(out_slot_reg);
    assign switched      = out_sw_reg;
    assign running_count = out_cnt_reg;
    assign refilled      = out_rf_reg;

    // Unwritten slots read as zero
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

    // Clamp refill priority bounds and active slot count
    always_comb
    begin
        lo_eff = (prio_lo_reg == '0) ? PRIO_W'(1) : prio_lo_reg;
        hi_eff = (prio_hi_reg < lo_eff) ? lo_eff : prio_hi_reg;
        span   = hi_eff - lo_eff + PRIO_W'(1);
        if (active_reg < ACTIVE_W'(2))
        begin
            limit = LIM_W'(2);
        end
        else if (32'(active_reg) > TASK_SLOTS)
        begin
            limit = LIM_W'(TASK_SLOTS);
        end
        else
        begin
            limit = LIM_W'(active_reg);
        end
    end

    assign scan_last = (LIM_W'(ptr_reg) == (limit - LIM_W'(1)));
    assign load_ok   = mode_reg && (idx_reg != '0) && (32'(idx_reg) < TASK_SLOTS);

    // Next state, memory access and result staging
    always_comb
    begin
        logic [LFSR_W-1:0] v1;
        logic [LFSR_W-1:0] v2;
        logic [PRIO_W:0]   part;
        logic              take;
        logic [SLOT_W-1:0] win;
        logic [COUNT_W-1:0] win_cnt;

        state_next       = state_reg;
        lfsr_next        = lfsr_reg;
        cur_next         = cur_reg;
        ptr_next         = ptr_reg;
        best_next        = best_reg;
        key_next         = key_reg;
        best_cnt_next    = best_cnt_reg;
        refill_done_next = refill_done_reg;
        fill_cnt_next    = fill_cnt_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        bit_cnt_next     = bit_cnt_reg;
        res_slot_next    = res_slot_reg;
        res_sw_next      = res_sw_reg;
        res_cnt_next     = res_cnt_reg;
        res_rf_next      = res_rf_reg;
        out_valid_next   = out_valid_reg;
        out_slot_next    = out_slot_reg;
        out_sw_next      = out_sw_reg;
        out_cnt_next     = out_cnt_reg;
        out_rf_next      = out_rf_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        v1               = lfsr_step(lfsr_reg);
        v2               = lfsr_step(v1);
        part             = {rem_reg, dvd_reg[LFSR_W-1]};
        take             = 1'b0;
        win              = best_reg;
        win_cnt          = best_cnt_reg;

        // Drop the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mode ? ST_LOAD_WR : ST_TICK_RD;
                end
            end

            ST_LOAD_WR:
            begin
                if (load_ok)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = SLOT_W'(idx_reg);
                    mem_wdata = '{count: lcount_reg, prio: lprio_reg};
                end
                state_next = ST_LOAD_RD;
            end

            ST_LOAD_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cur_reg;
                state_next = ST_LOAD_CAP;
            end

            ST_LOAD_CAP:
            begin
                res_slot_next = cur_reg;
                res_sw_next   = 1'b0;
                res_cnt_next  = rd_entry.count;
                res_rf_next   = 1'b0;
                state_next    = ST_DONE;
            end

            ST_TICK_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cur_reg;
                state_next = ST_TICK_CHK;
            end

            // Count down the running slot; rescan when it is idle or spent
            ST_TICK_CHK:
            begin
                refill_done_next = 1'b0;
                ptr_next         = SLOT_W'(1);
                best_next        = '0;
                key_next         = '0;
                best_cnt_next    = '0;
                state_next       = ST_SCAN_RD;
                if ((cur_reg != '0) && (rd_entry.count != '0))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg;
                    mem_wdata = '{count: rd_entry.count - COUNT_W'(1), prio: rd_entry.prio};
                    if (rd_entry.count != COUNT_W'(1))
                    begin
                        res_slot_next = cur_reg;
                        res_sw_next   = 1'b0;
                        res_cnt_next  = rd_entry.count - COUNT_W'(1);
                        res_rf_next   = 1'b0;
                        state_next    = ST_DONE;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_reg;
                state_next = ST_SCAN_EV;
            end

            // Compare one slot a cycle while the next read is in flight
            ST_SCAN_EV:
            begin
                if (rd_entry.count != '0)
                begin
                    if (policy_reg)
                    begin
                        take = (rd_entry.prio > key_reg);
                    end
                    else
                    begin
                        take = (best_reg == '0) || (rd_entry.count < key_reg);
                    end
                end
                if (take)
                begin
                    best_next     = ptr_reg;
                    key_next      = policy_reg ? rd_entry.prio : rd_entry.count;
                    best_cnt_next = rd_entry.count;
                    win           = ptr_reg;
                    win_cnt       = rd_entry.count;
                end
                if (scan_last)
                begin
                    if ((win == '0) && !refill_done_reg)
                    begin
                        ptr_next   = SLOT_W'(1);
                        state_next = ST_FILL_DRAW;
                    end
                    else
                    begin
                        cur_next      = win;
                        res_slot_next = win;
                        res_sw_next   = (win != cur_reg);
                        res_cnt_next  = win_cnt;
                        res_rf_next   = refill_done_reg;
                        state_next    = ST_DONE;
                    end
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + SLOT_W'(1);
                    ptr_next  = ptr_reg + SLOT_W'(1);
                end
            end

            // Two draws per slot: count from the first, priority from the second
            ST_FILL_DRAW:
            begin
                lfsr_next     = v2;
                fill_cnt_next = COUNT_W'(mod5(v1)) + COUNT_W'(1);
                dvd_next      = v2;
                rem_next      = '0;
                bit_cnt_next  = '0;
                state_next    = ST_FILL_DIV;
            end

            // Restoring remainder, one dividend bit a cycle
            ST_FILL_DIV:
            begin
                if (part >= {1'b0, span})
                begin
                    rem_next = PRIO_W'(part - {1'b0, span});
                end
                else
                begin
                    rem_next = part[PRIO_W-1:0];
                end
                dvd_next     = dvd_reg << 1;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(LFSR_W - 1))
                begin
                    state_next = ST_FILL_WR;
                end
            end

            ST_FILL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = '{count: fill_cnt_reg, prio: rem_reg + lo_eff};
                if (scan_last)
                begin
                    refill_done_next = 1'b1;
                    ptr_next         = SLOT_W'(1);
                    best_next        = '0;
                    key_next         = '0;
                    best_cnt_next    = '0;
                    state_next       = ST_SCAN_RD;
                end
                else
                begin
                    ptr_next   = ptr_reg + SLOT_W'(1);
                    state_next = ST_FILL_DRAW;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = res_slot_reg;
                    out_sw_next    = res_sw_reg;
                    out_cnt_next   = res_cnt_reg;
                    out_rf_next    = res_rf_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Seed write reloads the generator
        if (cfg_wr_en && (cfg_index == REG_SEED))
        begin
            lfsr_next = seed_fix(cfg_wr_data[LFSR_W-1:0]);
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POLICY_RESET;
            active_reg  <= ACTIVE_RESET;
            prio_lo_reg <= PRIO_LO_RESET;
            prio_hi_reg <= PRIO_HI_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POLICY:  policy_reg  <= cfg_wr_data[0];
                REG_ACTIVE:  active_reg  <= cfg_wr_data[ACTIVE_W-1:0];
                REG_PRIO_LO: prio_lo_reg <= cfg_wr_data[PRIO_W-1:0];
                REG_PRIO_HI: prio_hi_reg <= cfg_wr_data[PRIO_W-1:0];
                default:     ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lfsr_reg        <= seed_fix(SEED_RESET);
            cur_reg         <= '0;
            ptr_reg         <= '0;
            best_reg        <= '0;
            key_reg         <= '0;
            best_cnt_reg    <= '0;
            refill_done_reg <= 1'b0;
            bit_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            mem_valid_reg   <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lfsr_reg        <= lfsr_next;
            cur_reg         <= cur_next;
            ptr_reg         <= ptr_next;
            best_reg        <= best_next;
            key_reg         <= key_next;
            best_cnt_reg    <= best_cnt_next;
            refill_done_reg <= refill_done_next;
            bit_cnt_reg     <= bit_cnt_next;
            out_valid_reg   <= out_valid_next;
            if (mem_we)
            begin
                mem_valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_valid_reg <= mem_valid_reg[mem_raddr];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg   <= mode;
            idx_reg    <= slot_index;
            lcount_reg <= load_count;
            lprio_reg  <= load_priority;
        end
        fill_cnt_reg <= fill_cnt_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        res_slot_reg <= res_slot_next;
        res_sw_reg   <= res_sw_next;
        res_cnt_reg  <= res_cnt_next;
        res_rf_reg   <= res_rf_next;
        out_slot_reg <= out_slot_next;
        out_sw_reg   <= out_sw_next;
        out_cnt_reg  <= out_cnt_next;
        out_rf_reg   <= out_rf_next;
    end

    // Slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    `TSC_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != ST_IDLE)
    `TSC_ASSERT_IMPL(a_out_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE)
    `TSC_ASSERT_IMPL(a_no_idle_slot_write, mem_we, mem_waddr != '0)
    `TSC_ASSERT_IMPL(a_scan_in_range, state_reg == ST_SCAN_EV, LIM_W'(ptr_reg) < limit)
    `TSC_ASSERT_IMPL(a_refill_picks, (state_reg == ST_DONE) && res_rf_reg, res_slot_reg != '0)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the time-slice task scheduler core

localparam bit MODE_TICK       = 1'b0;
localparam bit MODE_LOAD       = 1'b1;
localparam bit POLICY_SHORTEST = 1'b0;
localparam bit POLICY_PRIORITY = 1'b1;
localparam int SLOTS           = tsts_pkg::TASK_SLOTS_DEF;

// One dispatch decision as the block reports it
typedef struct packed {
    logic [tsts_pkg::SLOT_IDX_W-1:0] slot;
    logic                            switched;
    logic [tsts_pkg::COUNT_W-1:0]    count;
    logic                            refilled;
} dispatch_t;

// Shadow slot table and dispatch queue
class dispatch_tracker;
    bit                          policy;
    logic [tsts_pkg::ACTIVE_W-1:0] active;
    logic [tsts_pkg::PRIO_W-1:0] prio_lo;
    logic [tsts_pkg::PRIO_W-1:0] prio_hi;
    logic [tsts_pkg::LFSR_W-1:0] lfsr;
    logic [tsts_pkg::COUNT_W-1:0] slice [SLOTS];
    logic [tsts_pkg::PRIO_W-1:0] prio [SLOTS];
    logic [tsts_pkg::SLOT_IDX_W-1:0] cur;
    dispatch_t                   pending_dispatch [$];
    int                          failures;

    function new();
        policy  = POLICY_SHORTEST;
        active  = 5'd2;
        prio_lo = 8'd1;
        prio_hi = 8'd10;
        lfsr    = 16'd44257;
        cur     = '0;
        failures = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slice[i] = '0;
            prio[i]  = '0;
        end
    endfunction

    function void write_reg(tsts_pkg::cfg_reg_t r, logic [15:0] d);
        case (r)
            tsts_pkg::REG_POLICY:  policy = d[0];
            tsts_pkg::REG_ACTIVE:  active = d[4:0];
            tsts_pkg::REG_PRIO_LO: prio_lo = d[7:0];
            tsts_pkg::REG_PRIO_HI: prio_hi = d[7:0];
            tsts_pkg::REG_SEED:    lfsr = (d == '0) ? 16'd1 : d;
            default: ;
        endcase
    endfunction

    // Clamp the active slot count into 2..SLOTS
    function int active_limit();
        int a;
        a = active;
        if (a < 2)
            a = 2;
        if (a > SLOTS)
            a = SLOTS;
        return a;
    endfunction

    function logic [15:0] draw();
        logic lsb;
        lsb = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb)
            lfsr = lfsr ^ tsts_pkg::LFSR_TAPS;
        return lfsr;
    endfunction

    // Return the winning slot, zero when none qualifies
    function logic [3:0] pick(int limit);
        logic [3:0] best;
        int key;
        best = '0;
        key = 0;
        for (int i = 1; i < limit; i++)
        begin
            if (slice[i] == 0)
                continue;
            if (policy == POLICY_PRIORITY)
            begin
                if (int'(prio[i]) > key)
                begin
                    key = prio[i];
                    best = 4'(i);
                end
            end
            else if (best == 0 || int'(slice[i]) < key)
            begin
                key = slice[i];
                best = 4'(i);
            end
        end
        return best;
    endfunction

    function void refill(int limit);
        int lo;
        int hi;
        int v1;
        int v2;
        lo = prio_lo;
        hi = prio_hi;
        if (lo == 0)
            lo = 1;
        if (hi < lo)
            hi = lo;
        for (int i = 1; i < limit; i++)
        begin
            v1 = int'(draw());
            v2 = int'(draw());
            slice[i] = 8'(v1 % tsts_pkg::COUNT_SPAN + 1);
            prio[i]  = 8'(v2 % (hi - lo + 1) + lo);
        end
    endfunction

    // Apply one accepted beat and queue the dispatch it must produce
    function void take_beat(bit m, logic [3:0] idx, logic [7:0] cnt, logic [7:0] pri);
        dispatch_t res;
        bit need;
        int limit;
        logic [3:0] next;
        res = '0;
        if (m == MODE_LOAD)
        begin
            if (idx != 0)
            begin
                slice[idx] = cnt;
                prio[idx]  = pri;
            end
        end
        else
        begin
            need = (cur == 0) || (slice[cur] == 0);
            if (!need)
            begin
                slice[cur] = slice[cur] - 8'd1;
                need = (slice[cur] == 0);
            end
            if (need)
            begin
                limit = active_limit();
                next = pick(limit);
                if (next == 0)
                begin
                    refill(limit);
                    res.refilled = 1'b1;
                    next = pick(limit);
                end
                if (next != cur)
                begin
                    res.switched = 1'b1;
                    cur = next;
                end
            end
        end
        res.slot  = cur;
        res.count = slice[cur];
        pending_dispatch.push_back(res);
    endfunction

    function void check_dispatch(dispatch_t got);
        dispatch_t exp;
        if (pending_dispatch.size() == 0)
        begin
            $display("%0t: unexpected beat, slot %0d count %0d", $time, got.slot, got.count);
            failures++;
            return;
        end
        exp = pending_dispatch.pop_front();
        if (got.slot !== exp.slot)
        begin
            $display("%0t: running_slot expected %0d actual %0d", $time, exp.slot, got.slot);
            failures++;
        end
        if (got.switched !== exp.switched)
        begin
            $display("%0t: switched expected %0b actual %0b", $time, exp.switched,
                     got.switched);
            failures++;
        end
        if (got.count !== exp.count)
        begin
            $display("%0t: running_count expected %0d actual %0d", $time, exp.count,
                     got.count);
            failures++;
        end
        if (got.refilled !== exp.refilled)
        begin
            $display("%0t: refilled expected %0b actual %0b", $time, exp.refilled,
                     got.refilled);
            failures++;
        end
    endfunction

    function int pending_count();
        return pending_dispatch.size();
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [3:0]  slot_index = '0;
    logic [7:0]  load_count = '0;
    logic [7:0]  load_priority = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  running_slot;
    logic        switched;
    logic [7:0]  running_count;
    logic        refilled;

    dispatch_tracker tracker;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;

    time_slice_task_scheduler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .slot_index    (slot_index),
        .load_count    (load_count),
        .load_priority (load_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .running_slot  (running_slot),
        .switched      (switched),
        .running_count (running_count),
        .refilled      (refilled)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check each output beat, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_dispatch({running_slot, switched, running_count, refilled});
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    // Offer one beat and hold it until accepted
    task automatic send_item(input bit m, input logic [3:0] idx, input logic [7:0] cnt,
                             input logic [7:0] pri);
        while (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        slot_index    <= idx;
        load_count    <= cnt;
        load_priority <= pri;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_beat(m, idx, cnt, pri);
    endtask

    task automatic write_reg(input tsts_pkg::cfg_reg_t r, input logic [15:0] d);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= r;
        cfg_wr_data <= d;
        @(posedge clk);
        tracker.write_reg(r, d);
    endtask

    // Drain the block, then rewrite every register; upper data bits carry junk
    task automatic reconfigure(input bit pol, input logic [4:0] act, input logic [7:0] lo,
                               input logic [7:0] hi, input logic [15:0] seed);
        logic [15:0] junk;
        in_valid <= 1'b0;
        while (tracker.pending_count() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        junk = 16'($urandom);
        write_reg(tsts_pkg::REG_POLICY, {junk[15:1], pol});
        write_reg(tsts_pkg::REG_ACTIVE, {junk[15:5], act});
        write_reg(tsts_pkg::REG_PRIO_LO, {junk[15:8], lo});
        write_reg(tsts_pkg::REG_PRIO_HI, {junk[7:0], hi});
        write_reg(tsts_pkg::REG_SEED, seed);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly short slices so ticks exhaust them; now and then zero or a long one
    function automatic logic [7:0] slice_value();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 8'd0;
        if (r < 18)
            return 8'($urandom_range(255));
        return 8'($urandom_range(1, 6));
    endfunction

    // Bursts of slot loads followed by runs of ticks
    task automatic run_traffic(input int n_items);
        int sent;
        int n_loads;
        int n_ticks;
        int limit;
        logic [3:0] idx;
        logic [7:0] pri;
        sent = 0;
        while (sent < n_items)
        begin
            limit = tracker.active_limit();
            n_loads = $urandom_range(0, limit);
            for (int i = 0; i < n_loads; i++)
            begin
                if ($urandom_range(99) < 15)
                    idx = 4'($urandom_range(15));
                else
                    idx = 4'($urandom_range(1, limit - 1));
                pri = ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(255));
                send_item(MODE_LOAD, idx, slice_value(), pri);
                if (idx != 0)
                    sent++;
            end
            n_ticks = $urandom_range(1, 12);
            for (int i = 0; i < n_ticks; i++)
            begin
                send_item(MODE_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick from idle with nothing loaded: refill at once
        send_item(MODE_TICK, 4'd0, 8'd0, 8'd0);
        // Load of the idle slot is dropped
        send_item(MODE_LOAD, 4'd0, 8'd255, 8'd255);
        // Load beyond the active range is stored but not a candidate
        send_item(MODE_LOAD, 4'd15, 8'd255, 8'd255);
        // Running slot already at zero
        send_item(MODE_LOAD, 4'd1, 8'd0, 8'd0);
        send_item(MODE_TICK, 4'd15, 8'd255, 8'd255);
        // Running slot reaches zero on this tick
        send_item(MODE_LOAD, 4'd1, 8'd1, 8'd0);
        send_item(MODE_TICK, 4'd0, 8'd0, 8'd0);

        // Shortest first with a tie on the smallest count
        reconfigure(POLICY_SHORTEST, 5'd16, 8'd1, 8'd10, 16'd44257);
        send_item(MODE_LOAD, 4'd2, 8'd3, 8'd7);
        send_item(MODE_LOAD, 4'd3, 8'd3, 8'd9);
        send_item(MODE_LOAD, 4'd4, 8'd255, 8'd1);
        repeat (4) send_item(MODE_TICK, 4'd0, 8'd0, 8'd0);

        // Highest priority with a tie, a zero priority never wins
        reconfigure(POLICY_PRIORITY, 5'd16, 8'd1, 8'd10, 16'd1234);
        send_item(MODE_LOAD, 4'd5, 8'd2, 8'd255);
        send_item(MODE_LOAD, 4'd6, 8'd2, 8'd255);
        send_item(MODE_LOAD, 4'd7, 8'd5, 8'd0);
        repeat (3) send_item(MODE_TICK, 4'd0, 8'd0, 8'd0);

        // Shrink the active range under a running slot
        reconfigure(POLICY_PRIORITY, 5'd4, 8'd1, 8'd10, 16'd1234);
        repeat (2) send_item(MODE_TICK, 4'd0, 8'd0, 8'd0);

        // Full range, zero seed
        reconfigure(POLICY_SHORTEST, 5'd16, 8'd1, 8'd255, 16'd0);
        run_traffic(200);
        // Active count above the table, zero low bound, inverted bounds
        reconfigure(POLICY_PRIORITY, 5'd31, 8'd0, 8'd0, 16'hFFFF);
        run_traffic(200);
        // Active count below two, top priority bounds
        reconfigure(POLICY_PRIORITY, 5'd0, 8'd255, 8'd255, 16'($urandom));
        run_traffic(150);

        // Hold the output off long enough to back up the input
        reconfigure(POLICY_SHORTEST, 5'd5, 8'd200, 8'd100, 16'($urandom));
        hold_req = 1'b1;
        run_traffic(200);

        // Run without idling on either side
        reconfigure(POLICY_PRIORITY, 5'd16, 8'd1, 8'd10, 16'($urandom));
        calm = 1'b1;
        run_traffic(250);
        calm = 1'b0;

        for (int p = 0; p < 5; p++)
        begin
            reconfigure(1'($urandom_range(1)), 5'($urandom_range(31)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        16'($urandom_range(65535)));
            run_traffic(130);
        end

        // Drain and let any stray beat show up
        in_valid <= 1'b0;
        while (tracker.pending_count() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending_count() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tsts_pkg.sv
hw/rtl/time_slice_task_scheduler_core.sv
tb/tb_top.sv
